FILE: rtl/core/dtu_pkg.sv
// Shared types and constants for the duration text parser.
package dtu_pkg;

	localparam int unsigned FRAC_DIGITS = 6;
	localparam logic [62:0] LIMIT63 = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [19:0] SCALE = 20'd1000000;

	localparam logic [31:0] MULT_US  = 32'd1;
	localparam logic [31:0] MULT_MS  = 32'd1000;
	localparam logic [31:0] MULT_S   = 32'd1000000;
	localparam logic [31:0] MULT_MIN = 32'd60000000;
	localparam logic [31:0] MULT_H   = 32'd3600000000;

	// largest integer part that still fits under the 63-bit limit per unit
	localparam logic [63:0] LIM_US  = 64'(LIMIT63);
	localparam logic [63:0] LIM_MS  = 64'(LIMIT63 / 63'd1000);
	localparam logic [63:0] LIM_S   = 64'(LIMIT63 / 63'd1000000);
	localparam logic [63:0] LIM_MIN = 64'(LIMIT63 / 63'd60000000);
	localparam logic [63:0] LIM_H   = 64'(LIMIT63 / 63'd3600000000);

	typedef enum logic [2:0] {
		U_NONE,
		U_US,
		U_MS,
		U_S,
		U_MIN,
		U_H
	} unit_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_UNKNOWN_UNIT = 3'd1,
		ST_NO_NUMBER   = 3'd2,
		ST_EMPTY       = 3'd3,
		ST_SATURATED   = 3'd4
	} status_t;

	// token from the parser: an optional term plus an optional end of string
	typedef struct packed {
		logic        term;
		logic        fin;
		status_t     err;
		unit_t       unit;
		logic [63:0] int_part;
		logic [9:0]  frac_hi;   // first three fraction digits
		logic [9:0]  frac_lo;   // next three fraction digits
	} tok_t;

	// term scaled to microseconds, ready for the accumulator
	typedef struct packed {
		logic        term;
		logic        fin;
		status_t     err;
		logic        ovf;
		logic [63:0] whole;
		logic [19:0] sub;
	} prod_t;

endpackage

FILE: rtl/core/dtu_parser.sv
// Byte parser: number and unit state, emits term and end tokens.
module dtu_parser #(
	parameter int MAX_NUMBER_CHARS = 127
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  logic           take,
	input  logic [7:0]     char_code,
	output dtu_pkg::tok_t  tok_s1
);
	import dtu_pkg::*;

	localparam int LW = $clog2(MAX_NUMBER_CHARS + 1);

	logic [63:0]   int_q;
	logic [9:0]    hi_q;
	logic [9:0]    lo_q;
	logic [2:0]    cnt_q;
	logic          dot_q;
	logic          frz_q;
	logic [LW-1:0] len_q;
	logic [23:0]   let_q;
	logic [2:0]    ulen_q;
	status_t       err_q;

	logic [63:0]   n_int;
	logic [9:0]    n_hi;
	logic [9:0]    n_lo;
	logic [2:0]    n_cnt;
	logic          n_dot;
	logic          n_frz;
	logic [LW-1:0] n_len;
	logic [23:0]   n_let;
	logic [2:0]    n_ulen;
	status_t       n_err;
	logic          emit;
	unit_t         tu;
	unit_t         ucode;
	logic          digit_hit;
	logic          is_num;
	logic          letter_hit;
	logic [7:0]    lc;
	logic [3:0]    dig;
	logic [67:0]   x10;
	logic [9:0]    place;
	tok_t          tok_n;

	always_comb begin
		ucode = U_NONE;
		case (ulen_q)
			3'd1: begin
				if (let_q == {16'h0, "s"}) ucode = U_S;
				else if (let_q == {16'h0, "h"}) ucode = U_H;
			end
			3'd2: begin
				if (let_q == {8'h0, "us"}) ucode = U_US;
				else if (let_q == {8'h0, "ms"}) ucode = U_MS;
				else if (let_q == {8'h0, "hr"}) ucode = U_H;
			end
			3'd3: begin
				if (let_q == "sec") ucode = U_S;
				else if (let_q == "min") ucode = U_MIN;
			end
			default: ucode = U_NONE;
		endcase
	end

	assign digit_hit  = (char_code >= "0") && (char_code <= "9");
	assign is_num     = digit_hit || (char_code == ".");
	assign letter_hit = ((char_code >= "a") && (char_code <= "z")) ||
			((char_code >= "A") && (char_code <= "Z"));
	assign lc  = char_code | 8'h20;
	assign dig = 4'(char_code - "0");

	always_comb begin
		n_int  = int_q;
		n_hi   = hi_q;
		n_lo   = lo_q;
		n_cnt  = cnt_q;
		n_dot  = dot_q;
		n_frz  = frz_q;
		n_len  = len_q;
		n_let  = let_q;
		n_ulen = ulen_q;
		n_err  = err_q;
		emit   = 1'b0;
		tu     = U_NONE;
		x10    = '0;
		place  = '0;

		if (err_q == ST_OK) begin
			if (is_num) begin
				if (ulen_q != 3'd0) begin
					if (len_q == '0) begin
						n_err = ST_NO_NUMBER;
					end else begin
						if (ucode == U_NONE) begin
							n_err = ST_UNKNOWN_UNIT;
						end else begin
							emit  = 1'b1;
							tu    = ucode;
							n_int = '0;
							n_hi  = '0;
							n_lo  = '0;
							n_cnt = '0;
							n_dot = 1'b0;
							n_frz = 1'b0;
							n_len = '0;
						end
						n_let  = '0;
						n_ulen = '0;
					end
				end
				// append to the (possibly fresh) number
				if (n_err == ST_OK && n_len < LW'(MAX_NUMBER_CHARS)) begin
					n_len = n_len + 1'b1;
					if (!n_frz) begin
						if (char_code == ".") begin
							if (n_dot) n_frz = 1'b1;
							else n_dot = 1'b1;
						end else if (!n_dot) begin
							x10 = {1'b0, n_int, 3'b000} + {3'b000, n_int, 1'b0} + 68'(dig);
							if (x10[67:64] != 4'd0) n_int = '1;
							else n_int = x10[63:0];
						end else if (n_cnt < 3'(FRAC_DIGITS)) begin
							case (n_cnt)
								3'd0, 3'd3: place = 10'd100;
								3'd1, 3'd4: place = 10'd10;
								default:    place = 10'd1;
							endcase
							if (n_cnt < 3'd3) n_hi = n_hi + 10'(dig * place);
							else n_lo = n_lo + 10'(dig * place);
							n_cnt = n_cnt + 1'b1;
						end
					end
				end
			end else if (letter_hit) begin
				if (ulen_q < 3'd3) n_let = {let_q[15:0], lc};
				if (ulen_q < 3'd4) n_ulen = ulen_q + 1'b1;
			end else if (len_q != '0) begin
				if (ulen_q != 3'd0 && ucode == U_NONE) begin
					n_err = ST_UNKNOWN_UNIT;
				end else begin
					emit  = 1'b1;
					tu    = (ulen_q != 3'd0) ? ucode : U_S;
					n_int = '0;
					n_hi  = '0;
					n_lo  = '0;
					n_cnt = '0;
					n_dot = 1'b0;
					n_frz = 1'b0;
					n_len = '0;
				end
				n_let  = '0;
				n_ulen = '0;
			end
		end

		tok_n.term     = emit;
		tok_n.fin      = (char_code == 8'd0);
		tok_n.err      = n_err;
		tok_n.unit     = tu;
		tok_n.int_part = int_q;
		tok_n.frac_hi  = hi_q;
		tok_n.frac_lo  = lo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q  <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
			cnt_q  <= '0;
			dot_q  <= 1'b0;
			frz_q  <= 1'b0;
			len_q  <= '0;
			let_q  <= '0;
			ulen_q <= '0;
			err_q  <= ST_OK;
			tok_s1 <= '0;
		end else if (adv) begin
			tok_s1 <= take ? tok_n : '0;
			if (take) begin
				if (char_code == 8'd0) begin
					int_q  <= '0;
					hi_q   <= '0;
					lo_q   <= '0;
					cnt_q  <= '0;
					dot_q  <= 1'b0;
					frz_q  <= 1'b0;
					len_q  <= '0;
					let_q  <= '0;
					ulen_q <= '0;
					err_q  <= ST_OK;
				end else begin
					int_q  <= n_int;
					hi_q   <= n_hi;
					lo_q   <= n_lo;
					cnt_q  <= n_cnt;
					dot_q  <= n_dot;
					frz_q  <= n_frz;
					len_q  <= n_len;
					let_q  <= n_let;
					ulen_q <= n_ulen;
					err_q  <= n_err;
				end
			end
		end
	end

endmodule

FILE: rtl/core/dtu_term.sv
// Term scaling: number times unit multiplier, split into whole and sub-us parts.
module dtu_term (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  dtu_pkg::tok_t  tok_s1,
	output dtu_pkg::prod_t prod_s3
);
	import dtu_pkg::*;

	logic [31:0] mult;
	logic [63:0] lim;
	logic [11:0] fmul;
	logic [19:0] frac;
	logic [63:0] plo;
	logic [63:0] phi;
	logic [31:0] fw;
	logic [19:0] sub;

	logic        term_s2;
	logic        fin_s2;
	status_t     err_s2;
	logic        ovf_s2;
	logic [63:0] plo_s2;
	logic [31:0] phi_s2;
	logic [31:0] fw_s2;
	logic [19:0] sub_s2;

	prod_t       prod_n;

	assign frac = 20'(tok_s1.frac_hi * 20'd1000) + 20'(tok_s1.frac_lo);

	always_comb begin
		mult = MULT_S;
		lim  = LIM_S;
		fmul = 12'd1;
		case (tok_s1.unit)
			U_US: begin
				mult = MULT_US;
				lim  = LIM_US;
				fmul = 12'd0;
			end
			U_MS: begin
				mult = MULT_MS;
				lim  = LIM_MS;
				fmul = 12'd0;
			end
			U_S: begin
				mult = MULT_S;
				lim  = LIM_S;
				fmul = 12'd1;
			end
			U_MIN: begin
				mult = MULT_MIN;
				lim  = LIM_MIN;
				fmul = 12'd60;
			end
			U_H: begin
				mult = MULT_H;
				lim  = LIM_H;
				fmul = 12'd3600;
			end
			default: begin
				mult = MULT_S;
				lim  = LIM_S;
				fmul = 12'd1;
			end
		endcase
	end

	assign plo = 64'(tok_s1.int_part[31:0]) * 64'(mult);
	assign phi = 64'(tok_s1.int_part[63:32]) * 64'(mult);

	// fraction: for us and ms the remainder below one microsecond survives
	always_comb begin
		fw  = 32'(frac) * 32'(fmul);
		sub = '0;
		case (tok_s1.unit)
			U_US: sub = frac;
			U_MS: begin
				fw  = 32'(tok_s1.frac_hi);
				sub = 20'(tok_s1.frac_lo * 20'd1000);
			end
			default: sub = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_s2 <= 1'b0;
			fin_s2  <= 1'b0;
			err_s2  <= ST_OK;
			ovf_s2  <= 1'b0;
			plo_s2  <= '0;
			phi_s2  <= '0;
			fw_s2   <= '0;
			sub_s2  <= '0;
		end else if (adv) begin
			term_s2 <= tok_s1.term;
			fin_s2  <= tok_s1.fin;
			err_s2  <= tok_s1.err;
			ovf_s2  <= tok_s1.int_part > lim;
			plo_s2  <= plo;
			phi_s2  <= phi[31:0];
			fw_s2   <= fw;
			sub_s2  <= sub;
		end
	end

	always_comb begin
		prod_n.term  = term_s2;
		prod_n.fin   = fin_s2;
		prod_n.err   = err_s2;
		prod_n.ovf   = ovf_s2;
		prod_n.whole = {phi_s2, 32'd0} + plo_s2 + 64'(fw_s2);
		prod_n.sub   = sub_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s3 <= '0;
		end else if (adv) begin
			prod_s3 <= prod_n;
		end
	end

endmodule

FILE: rtl/core/dtu_accum.sv
// Running total, saturation flag and the result register.
module dtu_accum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  dtu_pkg::prod_t prod_s3,
	output logic           out_valid_q,
	input  logic           out_ready,
	output logic [62:0]    dur_q,
	output dtu_pkg::status_t st_q
);
	import dtu_pkg::*;

	logic [62:0] whole_q;
	logic [19:0] sub_q;
	logic        ovf_q;

	logic [62:0] n_whole;
	logic [19:0] n_sub;
	logic        n_ovf;
	logic [20:0] sub_sum;
	logic        carry;
	logic [63:0] sum;
	status_t     st_n;
	logic [62:0] dur_n;

	always_comb begin
		n_whole = whole_q;
		n_sub   = sub_q;
		n_ovf   = ovf_q;
		sub_sum = 21'(sub_q) + 21'(prod_s3.sub);
		carry   = sub_sum >= 21'(SCALE);
		// 64-bit sum, wraps like the unsigned total it mirrors
		sum     = 64'(whole_q) + prod_s3.whole + 64'(carry);
		if (prod_s3.term && !ovf_q) begin
			if (prod_s3.ovf || sum > 64'(LIMIT63)) begin
				n_ovf = 1'b1;
			end else begin
				n_whole = sum[62:0];
				n_sub   = carry ? 20'(sub_sum - 21'(SCALE)) : sub_sum[19:0];
			end
		end

		dur_n = '0;
		if (prod_s3.err != ST_OK) st_n = prod_s3.err;
		else if (n_ovf) st_n = ST_SATURATED;
		else if (n_whole == '0 && n_sub == '0) st_n = ST_EMPTY;
		else begin
			st_n  = ST_OK;
			dur_n = n_whole;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q     <= '0;
			sub_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			dur_q       <= '0;
			st_q        <= ST_OK;
		end else begin
			if (adv && prod_s3.fin) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			if (adv) begin
				if (prod_s3.fin) begin
					whole_q <= '0;
					sub_q   <= '0;
					ovf_q   <= 1'b0;
					dur_q   <= dur_n;
					st_q    <= st_n;
				end else begin
					whole_q <= n_whole;
					sub_q   <= n_sub;
					ovf_q   <= n_ovf;
				end
			end
		end
	end

endmodule

FILE: rtl/core/duration_text_to_microseconds.sv
// Top level: duration text stream in, microsecond total stream out.
//
// Takes a duration string such as "1h 30min" or "2.5s", one byte per transfer on
// the s_ side; a zero byte ends the string. Units (us, ms, s, sec, min, h, hr)
// match in any case; a bare number counts as seconds. Arithmetic is exact
// decimal with six fraction digits, the total truncated to whole microseconds.
// One result transfer per string on the m_ side: duration_us and status
// (0 ok, 1 unknown unit, 2 unit lacks number, 3 empty or zero, 4 saturated).
// Rate: one byte per cycle, sustained. After the edge that takes the end byte,
// m_tvalid rises once the byte has passed the parser register, the multiply
// stage, the sum stage and the result register. The input side only
// stalls while an end token sits in the sum stage and the previous result is
// still waiting unaccepted in the result register.
module duration_text_to_microseconds #(
	parameter int MAX_NUMBER_CHARS = 127
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [62:0] duration_us, [65:63] status, rest zero
);
	import dtu_pkg::*;

	logic        adv;
	logic        take;
	tok_t        tok_s1;
	prod_t       prod_s3;
	logic [62:0] dur_q;
	status_t     st_q;

	// hold the pipe only when an end token meets a full, stalled result register
	assign adv      = !(m_tvalid && !m_tready && prod_s3.fin);
	assign s_tready = adv;
	assign take     = s_tvalid && adv;

	dtu_parser #(
		.MAX_NUMBER_CHARS(MAX_NUMBER_CHARS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.take     (take),
		.char_code(s_tdata),
		.tok_s1   (tok_s1)
	);

	dtu_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tok_s1 (tok_s1),
		.prod_s3(prod_s3)
	);

	dtu_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.prod_s3    (prod_s3),
		.out_valid_q(m_tvalid),
		.out_ready  (m_tready),
		.dur_q      (dur_q),
		.st_q       (st_q)
	);

	assign m_tdata = {6'd0, st_q, dur_q};

`ifndef ASSERT_OFF
	// end byte taken always yields an end token in the parser register
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tdata == 8'd0 |=> tok_s1.fin)
		else $error("end byte did not produce end token");

	// a blocked end token stays in place until the result is taken
	a_end_held: assert property (@(posedge clk) disable iff (!arst_n)
		prod_s3.fin && m_tvalid && !m_tready |=> prod_s3.fin && m_tvalid)
		else $error("end token lost while result register full");

	// a non-ok status never carries a duration
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st_q != ST_OK |-> dur_q == '0)
		else $error("error result with nonzero duration");
`endif

endmodule
